### src/uel_pkg.sv
// Package: shared types, constants and command/status structs for the line envelope block.
`timescale 1ns / 1ps
package uel_pkg;
   localparam int DefMaxLines = 64;
   localparam int ValW = 32;

   typedef logic signed [ValW-1:0] val_type;

   typedef struct packed {
      logic load;      // write input line at load pointer
      logic sort_rd;   // read pair for sort compare
      logic sort_sw;   // swap pair
      logic hull_rd;   // read store entry for hull pass
      logic hull_push; // push current line onto stack
      logic hull_pop;  // drop stack top
      logic mul_go;    // launch cross products
      logic out_rd;    // read stack entry for output
   } cmd_type;

   typedef struct packed {
      logic slope_eq;  // current line slope equals previous
      logic sw_need;   // sort pair out of order
      logic drop_mid;  // cross compare says drop top
   } sts_type;
endpackage

### src/uel_ctrl.sv
// Controller: sequences load, bubble sort, hull build and output.
`timescale 1ns / 1ps
module uel_ctrl #(
   parameter int MaxLines = uel_pkg::DefMaxLines,
   parameter int CntW = $clog2(MaxLines + 1)
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic last_line,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  uel_pkg::sts_type sts,
   output uel_pkg::cmd_type cmd,
   output logic [CntW-1:0] cnt,
   output logic [CntW-1:0] idx_a,
   output logic [CntW-1:0] hsz,
   output logic out_last
);
   import uel_pkg::*;

   localparam logic [3:0] S_LOAD = 4'd0, S_SRD = 4'd1, S_SCMP = 4'd2, S_HRD = 4'd3,
      S_HCHK = 4'd4, S_TRD = 4'd5, S_MUL = 4'd6, S_MUL2 = 4'd7, S_DEC = 4'd8,
      S_ORD = 4'd9, S_OUT = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in, i_ff, i_in, hsz_ff, hsz_in;
   logic swapped_ff, swapped_in;

   assign cnt = cnt_ff;
   assign idx_a = i_ff;
   assign hsz = hsz_ff;
   assign req_ready = (state_ff == S_LOAD);
   assign rsp_valid = (state_ff == S_OUT);
   assign out_last = (i_ff + CntW'(1) == hsz_ff);

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; i_in = i_ff; hsz_in = hsz_ff;
      swapped_in = swapped_ff;
      cmd = '0;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (cnt_ff < CntW'(MaxLines)) begin
                  cmd.load = 1'b1;
                  cnt_in = cnt_ff + CntW'(1);
               end
               if (last_line) begin
                  i_in = '0; swapped_in = 1'b0;
                  state_in = S_SRD;
               end
            end
         end
         S_SRD: begin
            // one bubble pass over [0, cnt-1)
            if (i_ff + CntW'(1) >= cnt_ff) begin
               if (swapped_ff) begin
                  i_in = '0; swapped_in = 1'b0; state_in = S_SRD;
               end else begin
                  i_in = '0; hsz_in = '0; state_in = S_HRD;
               end
            end else begin
               cmd.sort_rd = 1'b1; state_in = S_SCMP;
            end
         end
         S_SCMP: begin
            if (sts.sw_need) begin
               cmd.sort_sw = 1'b1; swapped_in = 1'b1;
            end
            i_in = i_ff + CntW'(1); state_in = S_SRD;
         end
         S_HRD: begin
            if (i_ff >= cnt_ff) begin
               cnt_in = '0; i_in = '0; state_in = S_ORD;
            end else begin
               cmd.hull_rd = 1'b1; state_in = S_HCHK;
            end
         end
         S_HCHK: begin
            if (i_ff != '0 && sts.slope_eq) begin
               i_in = i_ff + CntW'(1); state_in = S_HRD;
            end else state_in = S_TRD;
         end
         S_TRD: begin
            if (hsz_ff >= CntW'(2)) state_in = S_MUL;
            else begin
               cmd.hull_push = 1'b1; hsz_in = hsz_ff + CntW'(1);
               i_in = i_ff + CntW'(1); state_in = S_HRD;
            end
         end
         S_MUL: begin cmd.mul_go = 1'b1; state_in = S_MUL2; end
         S_MUL2: state_in = S_DEC;
         S_DEC: begin
            if (sts.drop_mid) begin
               cmd.hull_pop = 1'b1; hsz_in = hsz_ff - CntW'(1); state_in = S_TRD;
            end else begin
               cmd.hull_push = 1'b1; hsz_in = hsz_ff + CntW'(1);
               i_in = i_ff + CntW'(1); state_in = S_HRD;
            end
         end
         S_ORD: begin cmd.out_rd = 1'b1; state_in = S_OUT; end
         S_OUT: begin
            if (rsp_ready) begin
               if (out_last) state_in = S_LOAD;
               else begin i_in = i_ff + CntW'(1); state_in = S_ORD; end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; cnt_ff <= '0; i_ff <= '0; hsz_ff <= '0;
         swapped_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; i_ff <= i_in; hsz_ff <= hsz_in;
         swapped_ff <= swapped_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> hsz_ff != '0)
      else $error("output with empty hull");
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CntW'(MaxLines))
      else $error("line count overflow");
   assert property (@(posedge clock) disable iff (reset) hsz_ff <= CntW'(MaxLines))
      else $error("hull overflow");
   assert property (@(posedge clock) disable iff (reset) cmd.hull_pop |-> hsz_ff >= CntW'(2))
      else $error("pop below two");
endmodule

### src/uel_dp.sv
// Datapath: line store, hull stack, sort compare and cross-product compare.
`timescale 1ns / 1ps
module uel_dp #(
   parameter int MaxLines = uel_pkg::DefMaxLines,
   parameter int CntW = $clog2(MaxLines + 1)
) (
   input  logic clock,
   input  uel_pkg::cmd_type cmd,
   input  logic [CntW-1:0] cnt,
   input  logic [CntW-1:0] idx_a,
   input  logic [CntW-1:0] hsz,
   input  uel_pkg::val_type line_intercept,
   input  uel_pkg::val_type line_slope,
   output uel_pkg::sts_type sts,
   output uel_pkg::val_type hull_intercept,
   output uel_pkg::val_type hull_slope
);
   import uel_pkg::*;
   localparam int AW = (MaxLines > 1) ? $clog2(MaxLines) : 1;

   logic [2*ValW-1:0] store_mem [MaxLines];
   logic [2*ValW-1:0] stack_mem [MaxLines];

   val_type xi_ff, xs_ff, yi_ff, ys_ff;       // sort pair / current line
   val_type pi_ff, ps_ff;                     // previous line slope for dedup
   val_type ai_ff, as_ff, bi_ff, bs_ff;       // stack top two
   logic [ValW:0] m1a_ff, m1b_ff, m2a_ff, m2b_ff;
   logic n1_ff, n2_ff;
   logic [2*ValW+1:0] p1_ff, p2_ff;
   logic pn1_ff, pn2_ff;
   logic [AW-1:0] ia, ib, hb, ha;

   assign ia = idx_a[AW-1:0];
   assign ib = ia + AW'(1);
   assign hb = hsz[AW-1:0] - AW'(1);
   assign ha = hsz[AW-1:0] - AW'(2);

   function automatic logic [ValW:0] mag33(logic signed [ValW:0] d);
      return d[ValW] ? -d : d;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) store_mem[cnt[AW-1:0]] <= {line_intercept, line_slope};
      if (cmd.sort_rd) begin
         {xi_ff, xs_ff} <= store_mem[ia];
         {yi_ff, ys_ff} <= store_mem[ib];
      end
      if (cmd.sort_sw) begin
         store_mem[ia] <= {yi_ff, ys_ff};
         store_mem[ib] <= {xi_ff, xs_ff};
      end
      if (cmd.hull_rd) begin
         {yi_ff, ys_ff} <= store_mem[ia];
         pi_ff <= yi_ff; ps_ff <= ys_ff;
         {ai_ff, as_ff} <= stack_mem[ha];
         {bi_ff, bs_ff} <= stack_mem[hb];
      end
      if (cmd.hull_pop) begin
         bi_ff <= ai_ff; bs_ff <= as_ff;
         {ai_ff, as_ff} <= stack_mem[hsz[AW-1:0] - AW'(3)];
      end
      if (cmd.hull_push) stack_mem[hsz[AW-1:0]] <= {yi_ff, ys_ff};
      if (cmd.out_rd) {hull_intercept, hull_slope} <= stack_mem[ia];
      // stage 1: differences
      m1a_ff <= mag33({ai_ff[ValW-1], ai_ff} - {bi_ff[ValW-1], bi_ff});
      n1_ff  <= ($signed({ai_ff[ValW-1], ai_ff}) < $signed({bi_ff[ValW-1], bi_ff}));
      m2a_ff <= mag33({bi_ff[ValW-1], bi_ff} - {yi_ff[ValW-1], yi_ff});
      n2_ff  <= ($signed({bi_ff[ValW-1], bi_ff}) < $signed({yi_ff[ValW-1], yi_ff}));
      m2b_ff <= {bs_ff[ValW-1], bs_ff} - {ys_ff[ValW-1], ys_ff};
      m1b_ff <= {as_ff[ValW-1], as_ff} - {bs_ff[ValW-1], bs_ff};
      // stage 2: products, captured on launch
      if (cmd.mul_go) begin
         p1_ff <= {{(ValW+1){1'b0}}, m1a_ff} * {{(ValW+1){1'b0}}, m2b_ff};
         p2_ff <= {{(ValW+1){1'b0}}, m2a_ff} * {{(ValW+1){1'b0}}, m1b_ff};
         pn1_ff <= n1_ff && (m1a_ff != '0);
         pn2_ff <= n2_ff && (m2a_ff != '0);
      end
   end

   always_comb begin
      sts.sw_need = (ys_ff > xs_ff) || ((ys_ff == xs_ff) && (yi_ff > xi_ff));
      sts.slope_eq = (ys_ff == ps_ff);
      if (p1_ff == '0 && p2_ff == '0) sts.drop_mid = 1'b1;
      else if ((pn1_ff && p1_ff != '0) != (pn2_ff && p2_ff != '0))
         sts.drop_mid = !(pn1_ff && p1_ff != '0);
      else if (pn1_ff && p1_ff != '0) sts.drop_mid = (p1_ff <= p2_ff);
      else sts.drop_mid = (p1_ff >= p2_ff);
   end
endmodule

### src/upper_envelope_of_lines.sv
// Top level: upper envelope of lines (convex hull trick) with valid/ready beats.
// Operation: load beats are taken while loading; after the closing beat a bubble sort
// runs up to n passes, stopping after a pass with no swap, then the hull pass reads each line,
// skips equal slopes, and pops the stack while the cross compare drops its top.
// One set at a time: input stalls until the last output beat is taken.
// Reset (synchronous, active high) clears the counts and returns to loading.
`timescale 1ns / 1ps
module upper_envelope_of_lines #(
   parameter int MaxLines = uel_pkg::DefMaxLines
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  uel_pkg::val_type req_line_intercept,
   input  uel_pkg::val_type req_line_slope,
   input  logic req_last_line,
   output logic rsp_valid,
   input  logic rsp_ready,
   output uel_pkg::val_type rsp_hull_intercept,
   output uel_pkg::val_type rsp_hull_slope,
   output logic rsp_hull_last
);
   import uel_pkg::*;
   localparam int CntW = $clog2(MaxLines + 1);

   cmd_type cmd;
   sts_type sts;
   logic [CntW-1:0] cnt, idx_a, hsz;

   // controller: walks load, sort, hull and drain phases
   uel_ctrl #(.MaxLines(MaxLines), .CntW(CntW)) u_ctrl (
      .clock, .reset, .req_valid, .last_line(req_last_line), .req_ready,
      .rsp_valid, .rsp_ready, .sts, .cmd, .cnt, .idx_a, .hsz,
      .out_last(rsp_hull_last)
   );

   // datapath: stores, compares and cross products
   uel_dp #(.MaxLines(MaxLines), .CntW(CntW)) u_dp (
      .clock, .cmd, .cnt, .idx_a, .hsz,
      .line_intercept(req_line_intercept), .line_slope(req_line_slope), .sts,
      .hull_intercept(rsp_hull_intercept), .hull_slope(rsp_hull_slope)
   );
endmodule

### test/tb.sv
// Testbench for the upper envelope of lines block: directed and random line sets.
`timescale 1ns / 1ps
module tb;
   import uel_pkg::*;

   localparam int LineCap = DefMaxLines;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   val_type req_line_intercept = '0;
   val_type req_line_slope = '0;
   logic req_last_line = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   val_type rsp_hull_intercept;
   val_type rsp_hull_slope;
   logic rsp_hull_last;

   upper_envelope_of_lines dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_line_intercept(req_line_intercept),
      .req_line_slope(req_line_slope),
      .req_last_line(req_last_line),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hull_intercept(rsp_hull_intercept),
      .rsp_hull_slope(rsp_hull_slope),
      .rsp_hull_last(rsp_hull_last)
   );

   always #4 clock = ~clock;

   typedef struct {
      val_type icpt;
      val_type slope;
      logic    last;
   } hull_beat_type;

   typedef struct {
      longint icpt;
      longint slope;
   } line_rec_type;

   // Predictor state: lines gathered for the open set.
   line_rec_type pending_lines[$];
   hull_beat_type expected_hull[$];
   int fail_count = 0;
   int hold_off_cycles = 0;   // forced receiver stall, counted in the sink process
   bit sink_quiet = 0;        // no random stalls when set

   // True when (a.i-b.i)*(b.s-c.s) - (b.i-c.i)*(a.s-b.s) is not negative; computed in 128 bits.
   function automatic bit drop_middle(line_rec_type a, line_rec_type b, line_rec_type c);
      logic signed [127:0] lhs;
      logic signed [127:0] rhs;
      lhs = 128'(signed'(a.icpt - b.icpt)) * 128'(signed'(b.slope - c.slope));
      rhs = 128'(signed'(b.icpt - c.icpt)) * 128'(signed'(a.slope - b.slope));
      return lhs >= rhs;
   endfunction

   // Close the pending set: sort, dedupe slopes, build the envelope, queue beats.
   task automatic close_line_set();
      line_rec_type srt[$];
      line_rec_type stk[$];
      line_rec_type tmp;
      hull_beat_type hb;
      srt = pending_lines;
      for (int i = 1; i < srt.size(); i++) begin
         tmp = srt[i];
         for (int j = i; j > 0; j--) begin
            if (tmp.slope > srt[j-1].slope ||
                (tmp.slope == srt[j-1].slope && tmp.icpt > srt[j-1].icpt)) begin
               srt[j] = srt[j-1];
               srt[j-1] = tmp;
            end else begin
               break;
            end
         end
      end
      for (int i = 0; i < srt.size(); i++) begin
         if (i > 0 && srt[i-1].slope == srt[i].slope) continue;
         while (stk.size() >= 2 && drop_middle(stk[stk.size()-2], stk[stk.size()-1], srt[i]))
            stk.delete(stk.size() - 1);
         stk.insert(stk.size(), srt[i]);
      end
      foreach (stk[k]) begin
         hb.icpt = val_type'(stk[k].icpt);
         hb.slope = val_type'(stk[k].slope);
         hb.last = (k == stk.size() - 1);
         expected_hull.insert(expected_hull.size(), hb);
      end
      pending_lines.delete();
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   bit sender_quiet = 0;

   // Send one line beat; update the predictor when the beat is taken.
   task automatic send_line(val_type icpt, val_type slope, logic last);
      line_rec_type rec;
      int g;
      g = sender_quiet ? 0 : gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_line_intercept <= icpt;
      req_line_slope <= slope;
      req_last_line <= last;
      do @(posedge clock); while (!req_ready);
      if (pending_lines.size() < LineCap) begin
         rec.icpt = icpt;
         rec.slope = slope;
         pending_lines.insert(pending_lines.size(), rec);
      end
      if (last) close_line_set();
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (expected_hull.size() != 0 && guard < 400000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // Sink: random stalls, a long forced hold-off when asked, and the check.
   always @(posedge clock) begin
      hull_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hull.size() == 0) begin
            $display("%0t: unexpected beat icpt=%0d slope=%0d last=%0b", $time,
                     rsp_hull_intercept, rsp_hull_slope, rsp_hull_last);
            fail_count++;
         end else begin
            want = expected_hull.pop_front();
            if (want.icpt !== rsp_hull_intercept || want.slope !== rsp_hull_slope ||
                want.last !== rsp_hull_last) begin
               $display("%0t: expected icpt=%0d slope=%0d last=%0b got %0d %0d %0b",
                        $time, want.icpt, want.slope, want.last, rsp_hull_intercept,
                        rsp_hull_slope, rsp_hull_last);
               fail_count++;
            end
         end
      end
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (sink_quiet) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) < 70);
      end
   end

   function automatic val_type rand_val(int mode);
      case (mode)
         0: return val_type'($urandom);
         1: return val_type'($signed($urandom_range(0, 40)) - 20);
         default: return val_type'($signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   // Extremes, equal slopes, single line, parallel lines, dominated middles.
   task automatic test_directed();
      send_line(32'sh7fffffff, 32'sh80000000, 1'b1);
      send_line(32'sh80000000, 32'sh7fffffff, 1'b0);
      send_line(32'sh7fffffff, 32'sh80000000, 1'b0);
      send_line(32'sh80000000, 32'sh80000000, 1'b0);
      send_line(32'sh7fffffff, 32'sh7fffffff, 1'b1);
      send_line(5, 2, 1'b0);
      send_line(9, 2, 1'b0);
      send_line(-3, 2, 1'b1);
      send_line(0, 1, 1'b0);
      send_line(-10, 0, 1'b0);
      send_line(0, -1, 1'b1);
      send_line(0, 1, 1'b0);
      send_line(-1, 0, 1'b0);
      send_line(0, -1, 1'b1);
      send_line(32'shffffffff, 32'sh55555555, 1'b0);
      send_line(32'shaaaaaaaa, 32'shaaaaaaaa, 1'b0);
      send_line(32'sh55555555, 32'sh00000000, 1'b1);
      wait_drained();
   endtask

   // Overfill the store; extra lines are dropped, the closing one included.
   task automatic test_store_full();
      for (int i = 0; i < LineCap + 3; i++)
         send_line(rand_val(i % 3), rand_val(i % 3), i == LineCap + 2);
      wait_drained();
   endtask

   // Random sets, mostly small.
   task automatic test_random_sets();
      int sent;
      int n;
      int mode;
      sent = 0;
      while (sent < 100) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         mode = $urandom_range(0, 2);
         for (int i = 0; i < n; i++)
            send_line(rand_val(mode), rand_val(mode), i == n - 1);
         sent += n;
      end
      wait_drained();
   endtask

   // Hold the receiver off while the sender keeps offering, then drain; then a set with the receiver always ready.
   task automatic test_backpressure();
      hold_off_cycles = 3000;
      sender_quiet = 1;
      for (int s = 0; s < 3; s++)
         for (int i = 0; i < 6; i++)
            send_line(rand_val(2), rand_val(2), i == 5);
      sender_quiet = 0;
      wait_drained();
      sink_quiet = 1;
      for (int i = 0; i < 5; i++)
         send_line(rand_val(1), rand_val(1), i == 4);
      wait_drained();
      sink_quiet = 0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_store_full();
      test_backpressure();
      test_random_sets();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && expected_hull.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
